@@ hdl/mvc_pkg.sv @@
// ----------------------------------------------------------------------------
// mvc_pkg
// Types, codes and constants shared by the velocity curve remap block.
// ----------------------------------------------------------------------------
package mvc_pkg;

  localparam int NOTE_W      = 7;
  localparam int CHAN_W      = 5;
  localparam int CMD_W       = 2;
  localparam int PITCH_COUNT = 128;
  localparam int ACC_W       = 15;
  localparam int QUO_W       = 9;
  localparam int SUM_W       = 11;
  localparam int STEP_W      = 3;

  localparam int QDEPTH      = 2;
  localparam int QPTR_W      = $clog2(QDEPTH);
  localparam int QCNT_W      = $clog2(QDEPTH + 1);

  localparam int REG_IDX_W   = 3;
  localparam int REG_DATA_W  = 8;

  // register indexes
  localparam logic [REG_IDX_W-1:0] REG_CURVE_MODE      = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_SCALE_PERCENT   = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_VELOCITY_OFFSET = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_FIXED_VELOCITY  = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_TARGET_CHANNEL  = 3'd4;

  // curve modes
  localparam logic [1:0] CURVE_LINEAR = 2'd0;
  localparam logic [1:0] CURVE_ROOT   = 2'd1;
  localparam logic [1:0] CURVE_SQUARE = 2'd2;
  localparam logic [1:0] CURVE_CONST  = 2'd3;

  // event kinds on the wire
  localparam logic [CMD_W-1:0] CMD_NOTE_ON  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_NOTE_OFF = 2'd1;

  // reset values and arithmetic constants
  localparam logic [7:0]        SCALE_DEFAULT = 8'd100;
  localparam logic [NOTE_W-1:0] FIXED_DEFAULT = 7'd100;
  localparam logic [CHAN_W-1:0] CHAN_MAX      = 5'd16;
  localparam logic [NOTE_W-1:0] VEL_MAX       = 7'h7F;
  localparam int                PCT_BASE      = 100;
  localparam int                RECIP127_MUL  = 129;   // 16384/127, rounded down
  localparam int                RECIP127_SHR  = 14;
  localparam int                RECIP100_MUL  = 655;   // 65536/100, rounded down
  localparam int                RECIP100_SHR  = 16;
  localparam logic [STEP_W-1:0] ROOT_TOP_BIT  = 3'd6;

  typedef enum logic [1:0] {
    K_ON,
    K_OFF,
    K_PASS
  } kind_t;

  typedef enum logic [3:0] {
    B_IDLE,
    B_LOOK,
    B_SQRT,
    B_SQR,
    B_DIV127A,
    B_DIV127B,
    B_SCALE,
    B_DIV100A,
    B_DIV100B,
    B_EMIT
  } back_state_t;

  typedef struct packed {
    logic [CMD_W-1:0]  command;
    logic [CHAN_W-1:0] source_channel;
    logic [NOTE_W-1:0] note_number;
    logic [NOTE_W-1:0] note_velocity;
  } in_item_t;

  typedef struct packed {
    logic [CMD_W-1:0]  out_command;
    logic [CHAN_W-1:0] out_channel_number;
    logic [NOTE_W-1:0] out_note;
    logic [NOTE_W-1:0] out_velocity;
  } out_item_t;

  typedef struct packed {
    logic [1:0]        curve_mode;
    logic [7:0]        scale_percent;
    logic signed [7:0] velocity_offset;
    logic [NOTE_W-1:0] fixed_velocity;
    logic [CHAN_W-1:0] target_channel;
  } cfg_t;

  typedef struct packed {
    logic [CMD_W-1:0]  command;
    kind_t             kind;
    logic [NOTE_W-1:0] note;
    logic [NOTE_W-1:0] vel;
    logic [CHAN_W-1:0] chan;
  } qent_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_status_t;

endpackage

@@ hdl/midi_velocity_curve_remap.sv @@
// ----------------------------------------------------------------------------
// midi_velocity_curve_remap
// The back sequencer takes one event at a time: idle, look, emit. A linear
// or fixed note-on adds scale, div100a and div100b; the hard curve puts sqr,
// div127a, div127b before scale, the soft curve sqrt, one root bit a cycle.
// The front keeps taking beats into a two-entry queue meanwhile.
// Reset clears the registers to their defaults, the queue, the sequencer and
// the 128 pitch record valid bits; no clearing pass is needed.
// ----------------------------------------------------------------------------
module midi_velocity_curve_remap (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               item_valid,
  output logic                               item_stall,
  input  mvc_pkg::in_item_t                  item,
  output logic                               result_valid,
  input  logic                               result_stall,
  output mvc_pkg::out_item_t                 result,
  input  logic                               wr_en,
  input  logic [mvc_pkg::REG_IDX_W-1:0]      wr_index,
  input  logic [mvc_pkg::REG_DATA_W-1:0]     wr_data
);

  mvc_pkg::cfg_t      cfg;
  mvc_pkg::qent_t     q_in;
  mvc_pkg::qent_t     q_head;
  mvc_pkg::q_status_t q_status;
  logic               q_push;
  logic               q_pop;

  // Configuration registers. A zero scale or fixed velocity falls back to
  // the default; a target channel above sixteen is dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.curve_mode      <= mvc_pkg::CURVE_LINEAR;
      cfg.scale_percent   <= mvc_pkg::SCALE_DEFAULT;
      cfg.velocity_offset <= '0;
      cfg.fixed_velocity  <= mvc_pkg::FIXED_DEFAULT;
      cfg.target_channel  <= '0;
    end else if (wr_en) begin
      unique case (wr_index)
        mvc_pkg::REG_CURVE_MODE: begin
          cfg.curve_mode <= wr_data[1:0];
        end
        mvc_pkg::REG_SCALE_PERCENT: begin
          cfg.scale_percent <= (wr_data != '0) ? wr_data : mvc_pkg::SCALE_DEFAULT;
        end
        mvc_pkg::REG_VELOCITY_OFFSET: begin
          cfg.velocity_offset <= $signed(wr_data);
        end
        mvc_pkg::REG_FIXED_VELOCITY: begin
          cfg.fixed_velocity <= (wr_data[mvc_pkg::NOTE_W-1:0] != '0) ?
                                wr_data[mvc_pkg::NOTE_W-1:0] : mvc_pkg::FIXED_DEFAULT;
        end
        mvc_pkg::REG_TARGET_CHANNEL: begin
          if (wr_data[mvc_pkg::CHAN_W-1:0] <= mvc_pkg::CHAN_MAX) begin
            cfg.target_channel <= wr_data[mvc_pkg::CHAN_W-1:0];
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Front: take a beat whenever the queue has room, classify it and remap
  // its channel.
  mvc_front u_front (
    .item_valid (item_valid),
    .item_stall (item_stall),
    .item       (item),
    .cfg        (cfg),
    .q_status   (q_status),
    .push       (q_push),
    .entry      (q_in)
  );

  // Queue: decouple the front from the multi-cycle back.
  mvc_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .entry_in  (q_in),
    .pop       (q_pop),
    .entry_out (q_head),
    .status    (q_status)
  );

  // Back: look up the pitch record, reshape the velocity of a note-on and
  // hold the result beat in its output register until taken.
  mvc_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .q_head       (q_head),
    .q_status     (q_status),
    .pop          (q_pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

`ifndef SYNTH
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_status.full)
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !q_status.empty)
    else $error("queue read while empty");

  a_accept_fills: assert property (@(posedge clk) disable iff (rst)
    (item_valid && !item_stall && q_status.empty && !q_pop) |=> !q_status.empty)
    else $error("accepted beat did not reach the queue");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result valid straight after reset");
`endif

endmodule

@@ hdl/mvc_ram.sv @@
// ----------------------------------------------------------------------------
// mvc_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module mvc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hdl/mvc_queue.sv @@
// ----------------------------------------------------------------------------
// mvc_queue
// Short FIFO between the front and the back of the block.
// ----------------------------------------------------------------------------
module mvc_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  mvc_pkg::qent_t     entry_in,
  input  logic               pop,
  output mvc_pkg::qent_t     entry_out,
  output mvc_pkg::q_status_t status
);

  mvc_pkg::qent_t                  slots [mvc_pkg::QDEPTH];
  logic [mvc_pkg::QPTR_W-1:0]      wr_ptr;
  logic [mvc_pkg::QPTR_W-1:0]      rd_ptr;
  logic [mvc_pkg::QCNT_W-1:0]      count;

  function automatic logic [mvc_pkg::QPTR_W-1:0] wrap_inc(
    input logic [mvc_pkg::QPTR_W-1:0] p
  );
    if (p == mvc_pkg::QPTR_W'(mvc_pkg::QDEPTH - 1)) begin
      return '0;
    end
    return p + mvc_pkg::QPTR_W'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wrap_inc(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= wrap_inc(rd_ptr);
      end
      if (push && !pop) begin
        count <= count + mvc_pkg::QCNT_W'(1);
      end else if (pop && !push) begin
        count <= count - mvc_pkg::QCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= entry_in;
    end
  end

  assign entry_out    = slots[rd_ptr];
  assign status.empty = (count == '0);
  assign status.full  = (count == mvc_pkg::QCNT_W'(mvc_pkg::QDEPTH));

endmodule

@@ hdl/mvc_front.sv @@
// ----------------------------------------------------------------------------
// mvc_front
// Accepts note events, classifies them and remaps the channel.
// ----------------------------------------------------------------------------
module mvc_front (
  input  logic               item_valid,
  output logic               item_stall,
  input  mvc_pkg::in_item_t  item,
  input  mvc_pkg::cfg_t      cfg,
  input  mvc_pkg::q_status_t q_status,
  output logic               push,
  output mvc_pkg::qent_t     entry
);

  logic [mvc_pkg::CHAN_W-1:0] src_fold;
  logic [3:0]                 src_low;

  assign item_stall = q_status.full;
  assign push       = item_valid && !q_status.full;

  // fold any source channel onto 1..16
  assign src_low  = item.source_channel[3:0] + 4'd15;
  assign src_fold = {1'b0, src_low} + mvc_pkg::CHAN_W'(1);

  always_comb begin
    entry.command = item.command;
    entry.note    = item.note_number;
    entry.vel     = item.note_velocity;
    entry.chan    = (cfg.target_channel != '0) ? cfg.target_channel : src_fold;
    unique case (item.command)
      mvc_pkg::CMD_NOTE_ON:  entry.kind = mvc_pkg::K_ON;
      mvc_pkg::CMD_NOTE_OFF: entry.kind = mvc_pkg::K_OFF;
      default:               entry.kind = mvc_pkg::K_PASS;
    endcase
  end

endmodule

@@ hdl/mvc_back.sv @@
// ----------------------------------------------------------------------------
// mvc_back
// Sequencer that looks up the pitch record, reshapes note-on velocity and
// holds the result beat in the output register.
// ----------------------------------------------------------------------------
module mvc_back (
  input  logic               clk,
  input  logic               rst,
  input  mvc_pkg::cfg_t      cfg,
  input  mvc_pkg::qent_t     q_head,
  input  mvc_pkg::q_status_t q_status,
  output logic               pop,
  output logic               result_valid,
  input  logic               result_stall,
  output mvc_pkg::out_item_t result
);

  mvc_pkg::back_state_t state;
  mvc_pkg::back_state_t state_next;

  mvc_pkg::qent_t                   cur;
  logic [mvc_pkg::CHAN_W-1:0]       chan_sel;
  logic [mvc_pkg::NOTE_W-1:0]       vel_res;
  logic [mvc_pkg::NOTE_W-1:0]       curve;
  logic [mvc_pkg::ACC_W-1:0]        acc;
  logic [mvc_pkg::QUO_W-1:0]        quo;
  logic [mvc_pkg::STEP_W-1:0]       step;
  logic [mvc_pkg::PITCH_COUNT-1:0]  rec_valid;

  logic                             ram_we;
  logic [mvc_pkg::CHAN_W-1:0]       ram_rdata;
  logic                             out_free;
  logic                             load;

  logic [mvc_pkg::NOTE_W-1:0]       trial;
  logic [2*mvc_pkg::NOTE_W-1:0]     trial_sq;
  logic [20:0]                      prod127;
  logic [24:0]                      prod100;
  logic [mvc_pkg::ACC_W-1:0]        rem127;
  logic [mvc_pkg::ACC_W-1:0]        rem100;
  logic [mvc_pkg::QUO_W-1:0]        quo_fix;
  logic signed [mvc_pkg::SUM_W-1:0] vsum;
  logic [mvc_pkg::NOTE_W-1:0]       vclamp;

  mvc_ram #(
    .WIDTH (mvc_pkg::CHAN_W),
    .DEPTH (mvc_pkg::PITCH_COUNT)
  ) u_rec (
    .clk   (clk),
    .we    (ram_we),
    .waddr (cur.note),
    .wdata (cur.chan),
    .raddr (q_head.note),
    .rdata (ram_rdata)
  );

  assign out_free = !result_valid || !result_stall;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      mvc_pkg::B_IDLE: begin
        if (!q_status.empty) state_next = mvc_pkg::B_LOOK;
      end
      mvc_pkg::B_LOOK: begin
        if (cur.kind == mvc_pkg::K_ON) begin
          unique case (cfg.curve_mode)
            mvc_pkg::CURVE_ROOT:   state_next = mvc_pkg::B_SQRT;
            mvc_pkg::CURVE_SQUARE: state_next = mvc_pkg::B_SQR;
            default:               state_next = mvc_pkg::B_SCALE;
          endcase
        end else begin
          state_next = mvc_pkg::B_EMIT;
        end
      end
      mvc_pkg::B_SQRT: begin
        if (step == '0) state_next = mvc_pkg::B_SCALE;
      end
      mvc_pkg::B_SQR:     state_next = mvc_pkg::B_DIV127A;
      mvc_pkg::B_DIV127A: state_next = mvc_pkg::B_DIV127B;
      mvc_pkg::B_DIV127B: state_next = mvc_pkg::B_SCALE;
      mvc_pkg::B_SCALE:   state_next = mvc_pkg::B_DIV100A;
      mvc_pkg::B_DIV100A: state_next = mvc_pkg::B_DIV100B;
      mvc_pkg::B_DIV100B: state_next = mvc_pkg::B_EMIT;
      mvc_pkg::B_EMIT: begin
        if (out_free) state_next = mvc_pkg::B_IDLE;
      end
      default: state_next = mvc_pkg::B_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    pop    = (state == mvc_pkg::B_IDLE) && !q_status.empty;
    ram_we = (state == mvc_pkg::B_LOOK) && (cur.kind == mvc_pkg::K_ON);
    load   = (state == mvc_pkg::B_EMIT) && out_free;
  end

  // datapath
  always_comb begin
    trial    = curve | (mvc_pkg::NOTE_W'(1) << step);
    trial_sq = (2*mvc_pkg::NOTE_W)'(trial) * (2*mvc_pkg::NOTE_W)'(trial);
    prod127  = 21'(acc) * 21'(mvc_pkg::RECIP127_MUL);
    prod100  = 25'(acc) * 25'(mvc_pkg::RECIP100_MUL);
    rem127   = acc - mvc_pkg::ACC_W'(quo) * mvc_pkg::ACC_W'(mvc_pkg::VEL_MAX);
    rem100   = acc - mvc_pkg::ACC_W'(quo) * mvc_pkg::ACC_W'(mvc_pkg::PCT_BASE);
    quo_fix  = (rem100 >= mvc_pkg::ACC_W'(mvc_pkg::PCT_BASE)) ?
               quo + mvc_pkg::QUO_W'(1) : quo;
    vsum     = $signed({2'b00, quo_fix})
             + $signed({{(mvc_pkg::SUM_W-8){cfg.velocity_offset[7]}},
                        cfg.velocity_offset});
    if (vsum < $signed(mvc_pkg::SUM_W'(1))) begin
      vclamp = mvc_pkg::NOTE_W'(1);
    end else if (vsum > $signed({4'b0000, mvc_pkg::VEL_MAX})) begin
      vclamp = mvc_pkg::VEL_MAX;
    end else begin
      vclamp = vsum[mvc_pkg::NOTE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= mvc_pkg::B_IDLE;
      rec_valid    <= '0;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == mvc_pkg::B_LOOK) begin
        if (cur.kind == mvc_pkg::K_ON) begin
          rec_valid[cur.note] <= 1'b1;
        end else if (cur.kind == mvc_pkg::K_OFF) begin
          rec_valid[cur.note] <= 1'b0;
        end
      end
      if (load) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= q_head;
    end
    unique case (state)
      mvc_pkg::B_LOOK: begin
        chan_sel <= ((cur.kind == mvc_pkg::K_OFF) && rec_valid[cur.note]) ?
                    ram_rdata : cur.chan;
        vel_res  <= cur.vel;
        step     <= mvc_pkg::ROOT_TOP_BIT;
        unique case (cfg.curve_mode)
          mvc_pkg::CURVE_ROOT: begin
            curve <= '0;
            acc   <= mvc_pkg::ACC_W'(cur.vel) * mvc_pkg::ACC_W'(mvc_pkg::VEL_MAX);
          end
          mvc_pkg::CURVE_CONST: curve <= cfg.fixed_velocity;
          default:              curve <= cur.vel;
        endcase
      end
      mvc_pkg::B_SQRT: begin
        // one root bit per cycle, most significant first
        if (trial_sq <= acc[2*mvc_pkg::NOTE_W-1:0]) curve <= trial;
        step <= step - mvc_pkg::STEP_W'(1);
      end
      mvc_pkg::B_SQR: begin
        acc <= mvc_pkg::ACC_W'(cur.vel) * mvc_pkg::ACC_W'(cur.vel);
      end
      mvc_pkg::B_DIV127A: begin
        quo <= mvc_pkg::QUO_W'(prod127 >> mvc_pkg::RECIP127_SHR);
      end
      mvc_pkg::B_DIV127B: begin
        curve <= (rem127 >= mvc_pkg::ACC_W'(mvc_pkg::VEL_MAX)) ?
                 quo[mvc_pkg::NOTE_W-1:0] + mvc_pkg::NOTE_W'(1) :
                 quo[mvc_pkg::NOTE_W-1:0];
      end
      mvc_pkg::B_SCALE: begin
        acc <= mvc_pkg::ACC_W'(curve) * mvc_pkg::ACC_W'(cfg.scale_percent);
      end
      mvc_pkg::B_DIV100A: begin
        quo <= mvc_pkg::QUO_W'(prod100 >> mvc_pkg::RECIP100_SHR);
      end
      mvc_pkg::B_DIV100B: begin
        vel_res <= vclamp;
      end
      default: begin
      end
    endcase
    if (load) begin
      result.out_command        <= cur.command;
      result.out_channel_number <= chan_sel;
      result.out_note           <= cur.note;
      result.out_velocity       <= vel_res;
    end
  end

endmodule

@@ verif/midi_velocity_curve_remap_test.sv @@
// ----------------------------------------------------------------------------
// midi_velocity_curve_remap_test
// Self-checking bench for the velocity curve and channel remap block. A
// scoreboard predicts every outgoing event from the accepted input beats,
// the register settings and its own copy of the per-pitch channel record.
// Each output beat is compared field by field with the oldest prediction.
// The run covers a directed set, then phases of random traffic under
// extreme and random register settings, with bursty input and random
// output back-pressure.
// ----------------------------------------------------------------------------
module midi_velocity_curve_remap_test;
  timeunit 1ns;
  timeprecision 1ps;

  import mvc_pkg::*;

  // event kinds not named in the package
  localparam logic [CMD_W-1:0] CMD_OTHER = 2'd2;
  localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;

  // register indexes past the end of the register list
  localparam logic [REG_IDX_W-1:0] REG_UNUSED_LO = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_UNUSED_HI = 3'd7;

  localparam int RESET_CYCLES   = 8;
  localparam int SETTLE_CYCLES  = 16;    // longest per-event latency, with margin
  localparam int HOLD_CYCLES    = 300;   // long output hold-off
  localparam int WATCHDOG_LIMIT = 3000;  // cycles without any accepted beat
  localparam int PHASE_COUNT    = 10;
  localparam int PHASE_ITEMS    = 110;
  localparam int HOLD_PHASE     = 2;
  localparam int SHOW_LIMIT     = 10;

  // --------------------------------------------------------------------------
  // Scoreboard: register copy, pitch record and queue of predicted events
  // --------------------------------------------------------------------------
  class note_remap_board;
    logic [1:0]        curve;
    int                scale_pct;
    int                offset;
    int                fixed_vel;
    logic [CHAN_W-1:0] target;
    logic [CHAN_W-1:0] sounding [PITCH_COUNT];
    out_item_t         expected_events [$];
    int                failures;
    int                shown;

    function new();
      curve     = CURVE_LINEAR;
      scale_pct = int'(SCALE_DEFAULT);
      offset    = 0;
      fixed_vel = int'(FIXED_DEFAULT);
      target    = '0;
      foreach (sounding[i]) sounding[i] = '0;
      failures  = 0;
      shown     = 0;
    endfunction

    function void write_reg(logic [REG_IDX_W-1:0] idx, logic [REG_DATA_W-1:0] data);
      logic signed [7:0] ofs;
      case (idx)
        REG_CURVE_MODE:      curve = data[1:0];
        REG_SCALE_PERCENT:   scale_pct = (data == 0) ? int'(SCALE_DEFAULT) : int'(data);
        REG_VELOCITY_OFFSET: begin
          ofs    = data;
          offset = ofs;
        end
        REG_FIXED_VELOCITY:  fixed_vel = (data[NOTE_W-1:0] == 0) ? int'(FIXED_DEFAULT)
                                                                 : int'(data[NOTE_W-1:0]);
        REG_TARGET_CHANNEL:  if (data[CHAN_W-1:0] <= CHAN_MAX) target = data[CHAN_W-1:0];
        default: ;
      endcase
    endfunction

    function logic [NOTE_W-1:0] shape_velocity(logic [NOTE_W-1:0] vel);
      int v;
      int c;
      int r;
      v = int'(vel);
      case (curve)
        CURVE_ROOT: begin
          r = 0;
          while ((r + 1) * (r + 1) <= v * int'(VEL_MAX)) r++;
          c = r;
        end
        CURVE_SQUARE: c = (v * v) / int'(VEL_MAX);
        CURVE_CONST:  c = fixed_vel;
        default:      c = v;
      endcase
      c = (c * scale_pct) / PCT_BASE + offset;
      if (c < 1) c = 1;
      if (c > int'(VEL_MAX)) c = int'(VEL_MAX);
      return c[NOTE_W-1:0];
    endfunction

    // Fold the source channel into 1..16, then apply the target override.
    function logic [CHAN_W-1:0] route(logic [CHAN_W-1:0] src);
      logic [CHAN_W-1:0] s;
      s = ((src + 5'd15) & 5'd15) + 5'd1;
      return (target != 0) ? target : s;
    endfunction

    function void note_input(in_item_t x);
      out_item_t         e;
      logic [CHAN_W-1:0] ch;
      e.out_command  = x.command;
      e.out_note     = x.note_number;
      e.out_velocity = x.note_velocity;
      case (x.command)
        CMD_NOTE_ON: begin
          e.out_velocity = shape_velocity(x.note_velocity);
          ch = route(x.source_channel);
          sounding[x.note_number] = ch;
        end
        CMD_NOTE_OFF: begin
          ch = (sounding[x.note_number] != 0) ? sounding[x.note_number]
                                              : route(x.source_channel);
          sounding[x.note_number] = '0;
        end
        default: ch = route(x.source_channel);
      endcase
      e.out_channel_number = ch;
      expected_events.push_back(e);
    endfunction

    function void check_event(out_item_t got);
      out_item_t e;
      if (expected_events.size() == 0) begin
        failures++;
        if (shown < SHOW_LIMIT) begin
          shown++;
          $display("unexpected beat: cmd %0d ch %0d note %0d vel %0d", got.out_command,
                   got.out_channel_number, got.out_note, got.out_velocity);
        end
        return;
      end
      e = expected_events.pop_front();
      if (got.out_command != e.out_command || got.out_channel_number != e.out_channel_number ||
          got.out_note != e.out_note || got.out_velocity != e.out_velocity) begin
        failures++;
        if (shown < SHOW_LIMIT) begin
          shown++;
          $display("mismatch: expected cmd %0d ch %0d note %0d vel %0d", e.out_command,
                   e.out_channel_number, e.out_note, e.out_velocity);
          $display("          actual   cmd %0d ch %0d note %0d vel %0d", got.out_command,
                   got.out_channel_number, got.out_note, got.out_velocity);
        end
      end
    endfunction

    function int pending();
      return expected_events.size();
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset and block inputs, all known from time zero
  // --------------------------------------------------------------------------
  logic                  clk          = 1'b0;
  logic                  rst          = 1'b1;
  logic                  item_valid   = 1'b0;
  logic                  item_stall;
  in_item_t              item         = '0;
  logic                  result_valid;
  logic                  result_stall = 1'b0;
  out_item_t             result;
  logic                  wr_en        = 1'b0;
  logic [REG_IDX_W-1:0]  wr_index     = '0;
  logic [REG_DATA_W-1:0] wr_data      = '0;

  note_remap_board board = new();

  int burst_left   = 0;
  int quiet_cycles = 0;
  bit hold_request = 1'b0;   // raised by the sequence
  bit hold_active  = 1'b0;   // high while the receiver holds off
  bit hold_done    = 1'b0;
  int live_pitches [$];

  always #5 clk = ~clk;

  midi_velocity_curve_remap u_dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .wr_en        (wr_en),
    .wr_index     (wr_index),
    .wr_data      (wr_data)
  );

  // --------------------------------------------------------------------------
  // Monitor and watchdog. Sampling in the edge process sees the values from
  // before the edge, so every accepted beat is seen exactly once. Check the
  // output beat before noting the input beat: an event never leaves in the
  // cycle it enters.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst) begin
      if (result_valid && !result_stall) board.check_event(result);
      if (item_valid && !item_stall) board.note_input(item);
      if ((result_valid && !result_stall) || (item_valid && !item_stall)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no beat accepted for %0d cycles", WATCHDOG_LIMIT);
        $display("midi_velocity_curve_remap_test NOT OK");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Output back-pressure. Run segments of random length, each with its own
  // stall density (none, light, heavy). On request, hold the output off for
  // a long stretch so that the queue fills and the input stalls.
  // --------------------------------------------------------------------------
  initial begin : receiver
    int mode;
    int len;
    forever begin
      if (hold_request && !hold_done) begin
        hold_active = 1'b1;
        result_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_active = 1'b0;
        hold_done   = 1'b1;
      end else begin
        mode = $urandom_range(0, 2);
        len  = $urandom_range(10, 60);
        for (int k = 0; k < len && !(hold_request && !hold_done); k++) begin
          case (mode)
            0:       result_stall <= 1'b0;
            1:       result_stall <= ($urandom_range(0, 3) == 0);
            default: result_stall <= ($urandom_range(0, 9) < 7);
          endcase
          @(posedge clk);
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Driving tasks
  // --------------------------------------------------------------------------

  // Offer one beat and hold it until accepted. Keep valid high within a
  // burst (and throughout a hold-off, to fill the block); between bursts
  // drop valid for a random gap.
  task automatic offer(in_item_t x);
    item       <= x;
    item_valid <= 1'b1;
    do @(posedge clk); while (item_stall);
    if (hold_active || burst_left > 0) begin
      if (burst_left > 0) burst_left--;
    end else begin
      item_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 80)
                                                : $urandom_range(0, 20);
    end
  endtask

  // Stop sending and wait for every predicted event, then let the back
  // sequencer settle before touching the registers.
  task automatic drain();
    item_valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // One register write strobes wr_en, then releases it.
  task automatic set_reg(logic [REG_IDX_W-1:0] idx, logic [REG_DATA_W-1:0] data);
    wr_en    <= 1'b1;
    wr_index <= idx;
    wr_data  <= data;
    @(posedge clk);
    board.write_reg(idx, data);
    wr_en    <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_note(logic [CMD_W-1:0] cmd, logic [CHAN_W-1:0] ch,
                           logic [NOTE_W-1:0] note, logic [NOTE_W-1:0] vel);
    in_item_t x;
    x.command        = cmd;
    x.source_channel = ch;
    x.note_number    = note;
    x.note_velocity  = vel;
    offer(x);
  endtask

  // Register settings per phase: extremes first, then random data that
  // also hits the zero-means-default writes, ignored targets and spare
  // indexes.
  task automatic configure(int phase);
    case (phase)
      0: begin
        set_reg(REG_CURVE_MODE, REG_DATA_W'(CURVE_ROOT));
        set_reg(REG_SCALE_PERCENT, 8'd255);
        set_reg(REG_VELOCITY_OFFSET, 8'h7F);
        set_reg(REG_FIXED_VELOCITY, 8'd127);
        set_reg(REG_TARGET_CHANNEL, 8'd0);
      end
      1: begin
        set_reg(REG_CURVE_MODE, REG_DATA_W'(CURVE_SQUARE));
        set_reg(REG_SCALE_PERCENT, 8'd1);
        set_reg(REG_VELOCITY_OFFSET, 8'h80);
        set_reg(REG_FIXED_VELOCITY, 8'd1);
        set_reg(REG_TARGET_CHANNEL, REG_DATA_W'(CHAN_MAX));
      end
      2: begin
        set_reg(REG_CURVE_MODE, REG_DATA_W'(CURVE_CONST));
        set_reg(REG_SCALE_PERCENT, 8'd0);
        set_reg(REG_VELOCITY_OFFSET, 8'hFF);
        set_reg(REG_FIXED_VELOCITY, 8'd0);
        set_reg(REG_TARGET_CHANNEL, 8'd1);
      end
      3: begin
        set_reg(REG_CURVE_MODE, REG_DATA_W'(CURVE_LINEAR));
        set_reg(REG_SCALE_PERCENT, 8'd50);
        set_reg(REG_VELOCITY_OFFSET, 8'd10);
        set_reg(REG_FIXED_VELOCITY, 8'h80);
        set_reg(REG_TARGET_CHANNEL, 8'd17);   // out of range: keep channel 1
        set_reg(REG_TARGET_CHANNEL, 8'd31);
        set_reg(REG_UNUSED_LO, 8'hFF);
        set_reg(REG_UNUSED_HI, 8'h00);
      end
      default: begin
        set_reg(REG_CURVE_MODE, REG_DATA_W'($urandom_range(0, 255)));
        set_reg(REG_SCALE_PERCENT,
                REG_DATA_W'(($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 255)));
        set_reg(REG_VELOCITY_OFFSET, REG_DATA_W'($urandom_range(0, 255)));
        set_reg(REG_FIXED_VELOCITY, REG_DATA_W'($urandom_range(0, 255)));
        set_reg(REG_TARGET_CHANNEL, REG_DATA_W'($urandom_range(0, 31)));
        repeat ($urandom_range(0, 2)) begin
          set_reg(REG_IDX_W'($urandom_range(REG_UNUSED_LO, REG_UNUSED_HI)),
                  REG_DATA_W'($urandom_range(0, 255)));
        end
      end
    endcase
  endtask

  // Mostly note-on/note-off pairs on tracked pitches, so that the channel
  // record is read back; the rest is unstructured noise over every field.
  task automatic random_traffic(int count);
    int pick;
    int pitch;
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(0, 99) < 70) begin
        if (live_pitches.size() == 0 ||
            (live_pitches.size() < 12 && $urandom_range(0, 1) == 0)) begin
          pitch = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 127)
                                              : $urandom_range(60, 67);
          live_pitches.push_back(pitch);
          send_note(CMD_NOTE_ON, CHAN_W'($urandom_range(1, 16)), NOTE_W'(pitch),
                    NOTE_W'($urandom_range(0, 127)));
        end else begin
          pick  = $urandom_range(0, live_pitches.size() - 1);
          pitch = live_pitches[pick];
          live_pitches.delete(pick);
          send_note(CMD_NOTE_OFF, CHAN_W'($urandom_range(1, 16)), NOTE_W'(pitch),
                    NOTE_W'($urandom_range(0, 127)));
        end
      end else begin
        send_note(CMD_W'($urandom_range(0, 3)), CHAN_W'($urandom_range(0, 31)),
                  NOTE_W'($urandom_range(0, 127)), NOTE_W'($urandom_range(0, 127)));
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin : stimulus
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed set under reset defaults: velocity extremes and clamp to one,
    // note-off on a recorded pitch and on an unrecorded one, folding of
    // source channels out of range, other and spare commands.
    send_note(CMD_NOTE_ON,  5'd1,  7'd0,   7'd0);
    send_note(CMD_NOTE_ON,  5'd16, 7'd127, 7'd127);
    send_note(CMD_NOTE_OFF, 5'd5,  7'd0,   7'd64);
    send_note(CMD_NOTE_OFF, 5'd3,  7'd0,   7'd0);
    send_note(CMD_NOTE_ON,  5'd0,  7'd60,  7'd1);
    send_note(CMD_NOTE_ON,  5'd17, 7'd61,  7'd100);
    send_note(CMD_NOTE_ON,  5'd31, 7'd62,  7'd50);
    send_note(CMD_OTHER,    5'd9,  7'd10,  7'd127);
    send_note(CMD_SPARE,    5'd20, 7'd127, 7'd0);
    send_note(CMD_OTHER,    5'd0,  7'd0,   7'd85);
    send_note(CMD_NOTE_OFF, 5'd2,  7'd60,  7'd0);
    send_note(CMD_NOTE_OFF, 5'd2,  7'd61,  7'd127);
    send_note(CMD_NOTE_OFF, 5'd2,  7'd62,  7'd42);
    send_note(CMD_NOTE_OFF, 5'd0,  7'd127, 7'd127);
    send_note(CMD_NOTE_OFF, 5'd31, 7'd127, 7'd1);
    send_note(CMD_SPARE,    5'd31, 7'd85,  7'd42);
    drain();

    // Random phases; the record table carries over between settings, so
    // note-offs may leave on a channel the current target would not pick.
    for (int ph = 0; ph < PHASE_COUNT; ph++) begin
      configure(ph);
      if (ph == HOLD_PHASE) hold_request = 1'b1;
      random_traffic(PHASE_ITEMS);
      drain();
    end

    if (board.failures == 0 && board.pending() == 0) begin
      $display("midi_velocity_curve_remap_test OK");
    end else begin
      $display("midi_velocity_curve_remap_test NOT OK");
    end
    $finish;
  end

endmodule

@@ files.f @@
hdl/mvc_pkg.sv
hdl/mvc_ram.sv
hdl/mvc_queue.sv
hdl/mvc_front.sv
hdl/mvc_back.sv
hdl/midi_velocity_curve_remap.sv
verif/midi_velocity_curve_remap_test.sv
